### rtl/tsf_pkg.sv
// Shared types and constants for the tire slip force curve.
`default_nettype none

package tsf_pkg;

    localparam int SLIP_W = 32;
    localparam int CFG_W  = 31;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int FRAC_W = 16;

    // one divider stage per quotient bit, then the polynomial stages
    localparam int DIV_STAGES  = FRAC_W;
    localparam int POLY_STAGES = 5;
    localparam int N_STAGES    = 1 + DIV_STAGES + POLY_STAGES;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_EXT_SLIP  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_EXT_VAL   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ASY_SLIP  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ASY_VAL   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_STIFFNESS = 3'd4;

    localparam logic [CFG_W-1:0]  RST_EXT_SLIP  = 31'd65536;
    localparam logic [CFG_W-1:0]  RST_EXT_VAL   = 31'd1311;
    localparam logic [CFG_W-1:0]  RST_ASY_SLIP  = 31'd131072;
    localparam logic [CFG_W-1:0]  RST_ASY_VAL   = 31'd655;
    localparam logic [DATA_W-1:0] RST_STIFFNESS = 32'h7FFF_FFFF;

    localparam logic [CFG_W-1:0] FORCE_MAX = 31'h7FFF_FFFF;

    // curve segment codes
    localparam logic [1:0] SEG_RISE  = 2'd0;
    localparam logic [1:0] SEG_BLEND = 2'd1;
    localparam logic [1:0] SEG_TAIL  = 2'd2;

    typedef struct packed {
        logic       neg;
        logic [1:0] seg;
    } t_ctl;

endpackage

`default_nettype wire

### rtl/tire_slip_force_curve.sv
// Top level of the tire slip force curve: configuration, pipeline control, datapath.
// Throughput: one item per cycle while the output is not stalled.
// The divider takes one quotient bit per stage (16 stages).
// Each stage advances when its successor is empty or moving, so bubbles close up under stall.
// Reset clears every stage valid bit and loads the default curve configuration.
`default_nettype none

module tire_slip_force_curve (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [tsf_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire [tsf_pkg::DATA_W-1:0]    i_cfg_data,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire [tsf_pkg::SLIP_W-1:0]    i_slip,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [tsf_pkg::SLIP_W-1:0]   o_force_res,
    output logic                         o_config_valid
);

    localparam int NST = tsf_pkg::N_STAGES;
    localparam int ND  = tsf_pkg::DIV_STAGES;

    logic [tsf_pkg::CFG_W-1:0]  r_ext_slip, r_ext_val, r_asy_slip, r_asy_val;
    logic [tsf_pkg::DATA_W-1:0] r_stiff;
    logic                       w_cfg_ok;

    logic [NST-1:0]             r_vld;
    logic [NST-1:0]             w_en;

    logic [tsf_pkg::CFG_W-1:0]  w_rem  [0:ND];
    logic [tsf_pkg::FRAC_W-1:0] w_quo  [0:ND];
    logic [tsf_pkg::CFG_W-1:0]  w_span [0:ND];
    tsf_pkg::t_ctl              w_ctl  [0:ND];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_slip <= tsf_pkg::RST_EXT_SLIP;
            r_ext_val  <= tsf_pkg::RST_EXT_VAL;
            r_asy_slip <= tsf_pkg::RST_ASY_SLIP;
            r_asy_val  <= tsf_pkg::RST_ASY_VAL;
            r_stiff    <= tsf_pkg::RST_STIFFNESS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tsf_pkg::CFG_EXT_SLIP:  r_ext_slip <= i_cfg_data[tsf_pkg::CFG_W-1:0];
                tsf_pkg::CFG_EXT_VAL:   r_ext_val  <= i_cfg_data[tsf_pkg::CFG_W-1:0];
                tsf_pkg::CFG_ASY_SLIP:  r_asy_slip <= i_cfg_data[tsf_pkg::CFG_W-1:0];
                tsf_pkg::CFG_ASY_VAL:   r_asy_val  <= i_cfg_data[tsf_pkg::CFG_W-1:0];
                tsf_pkg::CFG_STIFFNESS: r_stiff    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_cfg_ok = (r_ext_slip != '0) && (r_ext_slip < r_asy_slip)
                   && (r_ext_val != '0) && (r_asy_val != '0)
                   && !r_stiff[tsf_pkg::DATA_W-1];

    // a stage loads when it is empty or its item moves on
    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || !i_stall;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0])
                r_vld[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                if (w_en[k])
                    r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NST-1];

    tsf_front u_front (
        .i_clk      (i_clk),
        .i_en       (w_en[0]),
        .i_slip     (i_slip),
        .i_ext_slip (r_ext_slip),
        .i_asy_slip (r_asy_slip),
        .o_rem      (w_rem[0]),
        .o_span     (w_span[0]),
        .o_ctl      (w_ctl[0])
    );

    assign w_quo[0] = '0;

    for (genvar g = 0; g < ND; g++) begin : g_div
        tsf_div_step u_step (
            .i_clk  (i_clk),
            .i_en   (w_en[g+1]),
            .i_rem  (w_rem[g]),
            .i_quo  (w_quo[g]),
            .i_span (w_span[g]),
            .i_ctl  (w_ctl[g]),
            .o_rem  (w_rem[g+1]),
            .o_quo  (w_quo[g+1]),
            .o_span (w_span[g+1]),
            .o_ctl  (w_ctl[g+1])
        );
    end

    tsf_poly u_poly (
        .i_clk          (i_clk),
        .i_en           (w_en[NST-1:ND+1]),
        .i_a            (w_quo[ND]),
        .i_ctl          (w_ctl[ND]),
        .i_ext_val      (r_ext_val),
        .i_asy_val      (r_asy_val),
        .i_cfg_ok       (w_cfg_ok),
        .o_force_res    (o_force_res),
        .o_config_valid (o_config_valid)
    );

    // input stall only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input stalled with a free stage");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted item not held in the input stage");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_config_valid) |-> (o_force_res == '0))
        else $error("nonzero force with invalid configuration");

    a_first_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && w_en[1]) |=> r_vld[1])
        else $error("item lost between input stage and divider");

endmodule

`default_nettype wire

### rtl/tsf_front.sv
// Input stage: slip magnitude, segment choice and divider operands.
`default_nettype none

module tsf_front (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire [tsf_pkg::SLIP_W-1:0]    i_slip,
    input  wire [tsf_pkg::CFG_W-1:0]     i_ext_slip,
    input  wire [tsf_pkg::CFG_W-1:0]     i_asy_slip,
    output logic [tsf_pkg::CFG_W-1:0]    o_rem,
    output logic [tsf_pkg::CFG_W-1:0]    o_span,
    output tsf_pkg::t_ctl                o_ctl
);

    logic [tsf_pkg::SLIP_W-1:0] w_mag;
    logic [tsf_pkg::CFG_W-1:0]  n_rem;
    logic [tsf_pkg::CFG_W-1:0]  n_span;
    tsf_pkg::t_ctl              n_ctl;

    // most negative slip wraps to 2^31, which lands on the tail
    assign w_mag = i_slip[tsf_pkg::SLIP_W-1] ? (~i_slip + 32'd1) : i_slip;

    always_comb begin
        n_ctl.neg = i_slip[tsf_pkg::SLIP_W-1];
        if (w_mag < {1'b0, i_ext_slip}) begin
            n_ctl.seg = tsf_pkg::SEG_RISE;
            n_rem     = w_mag[tsf_pkg::CFG_W-1:0];
            n_span    = i_ext_slip;
        end else if (w_mag < {1'b0, i_asy_slip}) begin
            n_ctl.seg = tsf_pkg::SEG_BLEND;
            n_rem     = w_mag[tsf_pkg::CFG_W-1:0] - i_ext_slip;
            n_span    = i_asy_slip - i_ext_slip;
        end else begin
            n_ctl.seg = tsf_pkg::SEG_TAIL;
            n_rem     = '0;
            n_span    = {{(tsf_pkg::CFG_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_span <= n_span;
            o_ctl  <= n_ctl;
        end
    end

endmodule

`default_nettype wire

### rtl/tsf_div_step.sv
// One restoring division stage: yields one quotient bit of the normalised slip.
`default_nettype none

module tsf_div_step (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire [tsf_pkg::CFG_W-1:0]     i_rem,
    input  wire [tsf_pkg::FRAC_W-1:0]    i_quo,
    input  wire [tsf_pkg::CFG_W-1:0]     i_span,
    input  wire tsf_pkg::t_ctl           i_ctl,
    output logic [tsf_pkg::CFG_W-1:0]    o_rem,
    output logic [tsf_pkg::FRAC_W-1:0]   o_quo,
    output logic [tsf_pkg::CFG_W-1:0]    o_span,
    output tsf_pkg::t_ctl                o_ctl
);

    logic [tsf_pkg::CFG_W:0]      w_trial;
    logic [tsf_pkg::CFG_W:0]      w_diff;
    logic                         w_bit;
    logic [tsf_pkg::CFG_W-1:0]    n_rem;

    assign w_trial = {i_rem, 1'b0};
    assign w_diff  = w_trial - {1'b0, i_span};
    assign w_bit   = (w_trial >= {1'b0, i_span});
    // remainder stays below the span, so the top bit drops
    assign n_rem   = w_bit ? w_diff[tsf_pkg::CFG_W-1:0] : w_trial[tsf_pkg::CFG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_quo  <= {i_quo[tsf_pkg::FRAC_W-2:0], w_bit};
            o_span <= i_span;
            o_ctl  <= i_ctl;
        end
    end

endmodule

`default_nettype wire

### rtl/tsf_poly.sv
// Cubic evaluation: powers of the normalised slip, blend product, clamp and sign.
`default_nettype none

module tsf_poly (
    input  wire                                i_clk,
    input  wire [tsf_pkg::POLY_STAGES-1:0]     i_en,
    input  wire [tsf_pkg::FRAC_W-1:0]          i_a,
    input  wire tsf_pkg::t_ctl                 i_ctl,
    input  wire [tsf_pkg::CFG_W-1:0]           i_ext_val,
    input  wire [tsf_pkg::CFG_W-1:0]           i_asy_val,
    input  wire                                i_cfg_ok,
    output logic [tsf_pkg::SLIP_W-1:0]         o_force_res,
    output logic                               o_config_valid
);

    // stage 0: a and a^2
    logic [tsf_pkg::FRAC_W-1:0]     r0_a, r0_a2;
    tsf_pkg::t_ctl                  r0_ctl;
    logic [2*tsf_pkg::FRAC_W-1:0]   w_sq;
    // stage 1: a^3
    logic [tsf_pkg::FRAC_W-1:0]     r1_a, r1_a2, r1_a3;
    tsf_pkg::t_ctl                  r1_ctl;
    logic [2*tsf_pkg::FRAC_W-1:0]   w_cube;
    // stage 2: multiplier operands
    logic [17:0]                    w_sum, w_a3x, w_rise;
    logic signed [19:0]             w_h;
    logic signed [19:0]             n_opb;
    logic signed [32:0]             n_opa;
    logic signed [19:0]             r2_opb;
    logic signed [32:0]             r2_opa;
    tsf_pkg::t_ctl                  r2_ctl;
    // stage 3: product
    logic signed [52:0]             w_prod;
    logic signed [52:0]             r3_prod;
    tsf_pkg::t_ctl                  r3_ctl;
    // stage 4: truncate, clamp, sign
    logic [52:0]                    w_mag;
    logic [36:0]                    w_m16;
    logic [39:0]                    w_term, w_sum40;
    logic [tsf_pkg::CFG_W-1:0]      w_f;
    logic [tsf_pkg::SLIP_W-1:0]     w_res;

    assign w_sq = i_a * i_a;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_a   <= i_a;
            r0_a2  <= w_sq[2*tsf_pkg::FRAC_W-1:tsf_pkg::FRAC_W];
            r0_ctl <= i_ctl;
        end
    end

    assign w_cube = r0_a * r0_a2;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_a   <= r0_a;
            r1_a2  <= r0_a2;
            r1_a3  <= w_cube[2*tsf_pkg::FRAC_W-1:tsf_pkg::FRAC_W];
            r1_ctl <= r0_ctl;
        end
    end

    always_comb begin
        w_sum  = {2'b0, r1_a} + {2'b0, r1_a2};
        w_a3x  = {2'b0, r1_a3};
        w_rise = (w_sum >= w_a3x) ? (w_sum - w_a3x) : 18'd0;
        // 3a^2 - 2a^3
        w_h    = $signed({3'b0, r1_a2, 1'b0}) + $signed({4'b0, r1_a2})
                 - $signed({3'b0, r1_a3, 1'b0});
        if (r1_ctl.seg == tsf_pkg::SEG_BLEND) begin
            n_opb = w_h;
            n_opa = $signed({2'b0, i_asy_val}) - $signed({2'b0, i_ext_val});
        end else begin
            n_opb = $signed({2'b0, w_rise});
            n_opa = $signed({2'b0, i_ext_val});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_opa <= n_opa;
            r2_opb <= n_opb;
            r2_ctl <= r1_ctl;
        end
    end

    assign w_prod = r2_opa * r2_opb;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_prod <= w_prod;
            r3_ctl  <= r2_ctl;
        end
    end

    always_comb begin
        // truncate the magnitude, then put the sign back
        w_mag   = r3_prod[52] ? (53'd0 - r3_prod) : r3_prod;
        w_m16   = w_mag[52:tsf_pkg::FRAC_W];
        w_term  = r3_prod[52] ? (40'd0 - {3'b0, w_m16}) : {3'b0, w_m16};
        w_sum40 = {9'b0, i_ext_val} + w_term;
        case (r3_ctl.seg)
            tsf_pkg::SEG_RISE: begin
                w_f = w_m16[tsf_pkg::CFG_W-1:0];
            end
            tsf_pkg::SEG_BLEND: begin
                if (w_sum40[39])
                    w_f = '0;
                else if (w_sum40 > {9'b0, tsf_pkg::FORCE_MAX})
                    w_f = tsf_pkg::FORCE_MAX;
                else
                    w_f = w_sum40[tsf_pkg::CFG_W-1:0];
            end
            tsf_pkg::SEG_TAIL: begin
                w_f = i_asy_val;
            end
            default: begin
                w_f = '0;
            end
        endcase
        w_res = r3_ctl.neg ? (32'd0 - {1'b0, w_f}) : {1'b0, w_f};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            o_force_res    <= i_cfg_ok ? w_res : '0;
            o_config_valid <= i_cfg_ok;
        end
    end

endmodule

`default_nettype wire

### sim/tb_tire_slip_force_curve.sv
// Testbench for the tire slip force curve: predicted forces checked against the pipeline.
module tb_tire_slip_force_curve;

    localparam int PIPE_LATENCY = tsf_pkg::N_STAGES;

    typedef struct packed {
        logic [tsf_pkg::SLIP_W-1:0] force_res;
        logic                       cfg_ok;
    } t_force_item;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [tsf_pkg::IDX_W-1:0]   i_cfg_idx;
    logic [tsf_pkg::DATA_W-1:0]  i_cfg_data;
    logic                        i_valid;
    logic                        o_stall;
    logic [tsf_pkg::SLIP_W-1:0]  i_slip;
    logic                        o_valid;
    logic                        i_stall;
    logic [tsf_pkg::SLIP_W-1:0]  o_force_res;
    logic                        o_config_valid;

    // shadow of the curve registers
    logic [tsf_pkg::CFG_W-1:0]   ext_slip;
    logic [tsf_pkg::CFG_W-1:0]   ext_val;
    logic [tsf_pkg::CFG_W-1:0]   asy_slip;
    logic [tsf_pkg::CFG_W-1:0]   asy_val;
    logic [tsf_pkg::DATA_W-1:0]  stiffness;

    t_force_item         pending_forces[$];
    int                  err_cnt = 0;
    int                  burst_left = 1;
    int                  stall_left = 0;
    int                  stall_phase = 0;
    t_stall_mode         stall_mode = STALL_NONE;

    tire_slip_force_curve i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_slip         (i_slip),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_force_res    (o_force_res),
        .o_config_valid (o_config_valid)
    );

    always #1 i_clk = ~i_clk;

    // force magnitude for a slip magnitude v under the shadow configuration
    function automatic longint unsigned curve_magnitude(input longint unsigned v);
        longint unsigned e_slip, e_val, a_slip, a_val, a, a2, a3, poly;
        longint          diff, h, prod, term, f;
        e_slip = ext_slip;
        e_val  = ext_val;
        a_slip = asy_slip;
        a_val  = asy_val;
        if (v < e_slip) begin
            a    = (v << tsf_pkg::FRAC_W) / e_slip;
            a2   = (a * a) >> tsf_pkg::FRAC_W;
            a3   = (a * a2) >> tsf_pkg::FRAC_W;
            poly = (a + a2 >= a3) ? a + a2 - a3 : 64'd0;
            return (e_val * poly) >> tsf_pkg::FRAC_W;
        end
        if (v < a_slip) begin
            a    = ((v - e_slip) << tsf_pkg::FRAC_W) / (a_slip - e_slip);
            a2   = (a * a) >> tsf_pkg::FRAC_W;
            a3   = (a * a2) >> tsf_pkg::FRAC_W;
            h    = 3 * longint'(a2) - 2 * longint'(a3);
            diff = longint'(a_val) - longint'(e_val);
            prod = diff * h;
            // truncate the magnitude, then restore the sign
            term = (prod < 0) ? -((-prod) >> tsf_pkg::FRAC_W) : (prod >> tsf_pkg::FRAC_W);
            f    = longint'(e_val) + term;
            if (f < 0) f = 0;
            if (f > longint'(tsf_pkg::FORCE_MAX)) f = longint'(tsf_pkg::FORCE_MAX);
            return longint'(f);
        end
        return a_val;
    endfunction

    function automatic t_force_item predict_force(input logic [tsf_pkg::SLIP_W-1:0] slip);
        t_force_item                r;
        logic                       neg;
        logic [tsf_pkg::SLIP_W-1:0] mag;
        logic [tsf_pkg::SLIP_W-1:0] f;
        longint unsigned            cm;
        neg = slip[tsf_pkg::SLIP_W-1];
        // the most negative slip keeps its magnitude of 2^31
        mag = neg ? (~slip + 1'b1) : slip;
        r.cfg_ok = (ext_slip != '0) && (ext_slip < asy_slip) && (ext_val != '0) &&
                   (asy_val != '0) && !stiffness[tsf_pkg::DATA_W-1];
        r.force_res = '0;
        if (r.cfg_ok) begin
            cm = curve_magnitude(mag);
            f  = cm[tsf_pkg::SLIP_W-1:0];
            r.force_res = neg ? (~f + 1'b1) : f;
        end
        return r;
    endfunction

    task automatic write_reg(input logic [tsf_pkg::IDX_W-1:0] idx,
                             input logic [tsf_pkg::DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            tsf_pkg::CFG_EXT_SLIP:  ext_slip  = data[tsf_pkg::CFG_W-1:0];
            tsf_pkg::CFG_EXT_VAL:   ext_val   = data[tsf_pkg::CFG_W-1:0];
            tsf_pkg::CFG_ASY_SLIP:  asy_slip  = data[tsf_pkg::CFG_W-1:0];
            tsf_pkg::CFG_ASY_VAL:   asy_val   = data[tsf_pkg::CFG_W-1:0];
            tsf_pkg::CFG_STIFFNESS: stiffness = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold the sender until every predicted force has come back
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_forces.size() != 0);
    endtask

    task automatic set_curve(input logic [tsf_pkg::DATA_W-1:0] es,
                             input logic [tsf_pkg::DATA_W-1:0] ev,
                             input logic [tsf_pkg::DATA_W-1:0] as_slip,
                             input logic [tsf_pkg::DATA_W-1:0] av,
                             input logic [tsf_pkg::DATA_W-1:0] st);
        wait_idle();
        write_reg(tsf_pkg::CFG_EXT_SLIP, es);
        write_reg(tsf_pkg::CFG_EXT_VAL, ev);
        write_reg(tsf_pkg::CFG_ASY_SLIP, as_slip);
        write_reg(tsf_pkg::CFG_ASY_VAL, av);
        write_reg(tsf_pkg::CFG_STIFFNESS, st);
    endtask

    task automatic send_slip(input logic [tsf_pkg::SLIP_W-1:0] s);
        int gap;
        i_valid <= 1'b1;
        i_slip  <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_forces.push_back(predict_force(s));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 20);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [tsf_pkg::SLIP_W-1:0] random_slip();
        logic [tsf_pkg::SLIP_W-1:0] m;
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: m = ext_slip + $urandom_range(0, 16) - 8;
            2: m = asy_slip + $urandom_range(0, 16) - 8;
            3: m = $urandom_range(0, {1'b0, asy_slip} + (asy_slip >> 2));
            4: m = $urandom_range(0, 15);
            default: m = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
        return $urandom_range(0, 1) ? (~m + 1'b1) : m;
    endfunction

    task automatic random_curve();
        logic [tsf_pkg::DATA_W-1:0] es, span, ev, av, st;
        case ($urandom_range(0, 3))
            0: es = $urandom_range(1, 64);
            1: es = $urandom_range(1 << 12, 1 << 18);
            2: es = $urandom_range(1 << 18, 1 << 28);
            default: es = $urandom_range(1 << 28, 1 << 30);
        endcase
        span = $urandom_range(1, 1 << $urandom_range(0, 28));
        // now and then collapse the blend span to break the ordering
        if ($urandom_range(0, 9) == 0) span = '0;
        ev = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 20);
        av = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 20);
        st = $urandom();
        if ($urandom_range(0, 9) != 0) st[tsf_pkg::DATA_W-1] = 1'b0;
        set_curve(es, ev, es + span, av, st);
    endtask

    // check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_force_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_forces.size() == 0) begin
                $display("%0t: unexpected item force_res=%h config_valid=%b",
                         $time, o_force_res, o_config_valid);
                err_cnt++;
            end else begin
                want = pending_forces.pop_front();
                if (o_force_res !== want.force_res) begin
                    $display("%0t: force_res mismatch: expected %h, actual %h",
                             $time, want.force_res, o_force_res);
                    err_cnt++;
                end
                if (o_config_valid !== want.cfg_ok) begin
                    $display("%0t: config_valid mismatch: expected %b, actual %b",
                             $time, want.cfg_ok, o_config_valid);
                    err_cnt++;
                end
            end
        end
    end

    // receiver back-pressure: a random stall pattern, switched after a random run
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            STALL_NONE:     i_stall <= 1'b0;
            STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: i_stall <= ((stall_phase % 5) < 2);
            default:        i_stall <= 1'b0;
        endcase
    end

    task automatic test_default_curve();
        logic [tsf_pkg::SLIP_W-1:0] pts [10] = '{32'd0, 32'd1, 32'd65535, 32'd65536,
                                                 32'd98304, 32'd131071, 32'd131072,
                                                 32'h7FFF_FFFF, 32'h8000_0000,
                                                 32'hFFFF_FFFF};
        foreach (pts[k]) send_slip(pts[k]);
    endtask

    task automatic test_config_checks();
        logic [tsf_pkg::IDX_W-1:0] idx;
        set_curve(32'd0, 32'd1311, 32'd131072, 32'd655, tsf_pkg::RST_STIFFNESS);
        send_slip(32'd40000);
        set_curve(32'd131072, 32'd1311, 32'd131072, 32'd655, tsf_pkg::RST_STIFFNESS);
        send_slip(-32'sd40000);
        set_curve(32'd200000, 32'd1311, 32'd131072, 32'd655, tsf_pkg::RST_STIFFNESS);
        send_slip(32'd150000);
        set_curve(32'd65536, 32'd0, 32'd131072, 32'd655, tsf_pkg::RST_STIFFNESS);
        send_slip(-32'sd100000);
        set_curve(32'd65536, 32'd1311, 32'd131072, 32'd0, tsf_pkg::RST_STIFFNESS);
        send_slip(32'd100000);
        set_curve(32'd65536, 32'd1311, 32'd131072, 32'd655, 32'h8000_0000);
        send_slip(32'd50000);
        // zero stiffness is still valid; the top bit of a 31-bit register is dropped
        set_curve(32'd65536, 32'd1311, 32'hFFFF_FFFF, 32'd655, 32'd0);
        send_slip(-32'sd1000000);
        wait_idle();
        for (idx = tsf_pkg::CFG_STIFFNESS + 1'b1; idx != '0; idx++) write_reg(idx, '0);
        send_slip(32'd70000);
    endtask

    task automatic test_curve_extremes();
        set_curve(32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd0);
        send_slip(32'd0);
        send_slip(32'd1);
        send_slip(32'h4000_0000);
        send_slip(32'hC000_0001);
        set_curve(32'h7FFF_FFFE, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  tsf_pkg::RST_STIFFNESS);
        send_slip(32'h7FFF_FFFD);
        send_slip(32'h8000_0002);
    endtask

    task automatic test_random_stream();
        int n;
        for (n = 0; n < 600; n++) begin
            if (n % 60 == 0) random_curve();
            else if (n % 60 == 30) wait_idle();
            send_slip(random_slip());
        end
    endtask

    initial begin
        ext_slip  = tsf_pkg::RST_EXT_SLIP;
        ext_val   = tsf_pkg::RST_EXT_VAL;
        asy_slip  = tsf_pkg::RST_ASY_SLIP;
        asy_val   = tsf_pkg::RST_ASY_VAL;
        stiffness = tsf_pkg::RST_STIFFNESS;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_slip     <= '0;
        i_stall    <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_curve();
        test_config_checks();
        test_curve_extremes();
        test_random_stream();
        wait_idle();
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/tsf_pkg.sv
rtl/tsf_front.sv
rtl/tsf_div_step.sv
rtl/tsf_poly.sv
rtl/tire_slip_force_curve.sv
sim/tb_tire_slip_force_curve.sv
